### src/acl_access_checker_macros.svh
// Assertion macros used by the access checker top level.
`ifndef ACL_ACCESS_CHECKER_MACROS_SVH
`define ACL_ACCESS_CHECKER_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ACL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acl_access_checker: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define ACL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acl_access_checker: next-cycle check failed");

`endif

### src/acl_pkg.sv
// Shared constants, types and codes of the access checker.
`timescale 1ns / 1ps

package acl_pkg;

  // Sizes of the list and of its fields.
  localparam int unsigned AclDepth      = 16;
  localparam int unsigned RightsWidth   = 16;
  localparam int unsigned IdWidth       = 32;
  localparam int unsigned GenWidth      = 32;
  localparam int unsigned IdxWidth      = (AclDepth > 1) ? $clog2(AclDepth) : 1;
  localparam int unsigned CntWidth      = $clog2(AclDepth + 1);
  localparam int unsigned InIdxWidth    = 4;
  localparam int unsigned InLenWidth    = 5;
  localparam int unsigned CfgIdxWidth   = 2;

  // Rights bits with a fixed meaning.
  localparam int unsigned ExecuteMask   = 4;
  localparam int unsigned ReferenceMask = 1;

  typedef logic [IdWidth-1:0]     id_t;
  typedef logic [RightsWidth-1:0] rights_t;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_CRED   = 2'd2
  } op_e;

  // Result codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DENIED   = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PRIVILEGED_ID = 2'd0,
    CFG_WILDCARD_ID   = 2'd1
  } cfg_reg_e;

  // Operands handed to the shared match unit for one slot.
  typedef struct packed {
    logic    priv_mode;
    id_t     cred_id;
    id_t     wildcard_id;
    rights_t want;
    rights_t gathered;
    id_t     slot_id;
    rights_t slot_rights;
  } match_req_t;

  // Outcome of the match unit for one slot.
  typedef struct packed {
    logic    hit;
    rights_t gathered;
  } match_rsp_t;

endpackage

### src/acl_table.sv
// Slot store of the access control list, with reset contents.
`timescale 1ns / 1ps

module acl_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [acl_pkg::IdxWidth-1:0]  wr_idx_i,
  input  acl_pkg::id_t                  wr_id_i,
  input  acl_pkg::rights_t              wr_rights_i,
  input  logic [acl_pkg::IdxWidth-1:0]  rd_idx_i,
  output acl_pkg::id_t                  rd_id_o,
  output acl_pkg::rights_t              rd_rights_o
);

  acl_pkg::id_t     ids_q    [acl_pkg::AclDepth];
  acl_pkg::rights_t rights_q [acl_pkg::AclDepth];

  // Slot zero comes out of reset holding the reference right, the rest empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < acl_pkg::AclDepth; k++) begin
        ids_q[k]    <= '0;
        rights_q[k] <= (k == 0) ? acl_pkg::rights_t'(acl_pkg::ReferenceMask) : '0;
      end
    end else if (wr_en_i) begin
      ids_q[wr_idx_i]    <= wr_id_i;
      rights_q[wr_idx_i] <= wr_rights_i;
    end
  end

  // The walk reads one slot per cycle.
  assign rd_id_o     = ids_q[rd_idx_i];
  assign rd_rights_o = rights_q[rd_idx_i];

endmodule

### src/acl_match_unit.sv
// Shared compare and merge unit applied to one slot per cycle.
`timescale 1ns / 1ps

module acl_match_unit (
  input  acl_pkg::match_req_t req_i,
  output acl_pkg::match_rsp_t rsp_o
);

  acl_pkg::rights_t exec_mask;
  acl_pkg::rights_t merged;
  logic             id_match;
  logic             exec_match;

  assign exec_mask  = acl_pkg::rights_t'(acl_pkg::ExecuteMask);
  assign merged     = req_i.gathered | req_i.slot_rights;
  assign id_match   = (req_i.slot_id == req_i.cred_id) || (req_i.slot_id == req_i.wildcard_id);
  assign exec_match = |(req_i.slot_rights & exec_mask);

  // A privileged request only looks for an execute right; any other request
  // collects the rights of matching slots until they cover what it wants.
  always_comb begin
    if (req_i.priv_mode) begin
      rsp_o.hit      = exec_match;
      rsp_o.gathered = req_i.gathered;
    end else begin
      rsp_o.hit      = id_match && ((merged & req_i.want) == req_i.want);
      rsp_o.gathered = id_match ? merged : req_i.gathered;
    end
  end

endmodule

### src/acl_access_checker.sv
// Top level of the access checker: sequencer, header state and ports.
`timescale 1ns / 1ps

// An entry write is taken while idle and goes straight into the slot store; a header item
// leaves its result through the output register. A credential goes straight to the
// result step when its request is already decided, comes from the privileged id without
// asking for an execute right, or finds no slots in use; otherwise the single match unit
// compares one slot each cycle and the walk stops at the first slot that decides the
// request, or after the last slot in use. The input stalls while an item is in
// work, and a result waits in that work while the previous one is still held.
// Configuration writes are always taken.

module acl_access_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [acl_pkg::GenWidth-1:0]     generation_i,
  input  logic [acl_pkg::InLenWidth-1:0]   list_length_i,
  input  logic [acl_pkg::InIdxWidth-1:0]   entry_index_i,
  input  logic [acl_pkg::IdWidth-1:0]      entry_id_i,
  input  logic [15:0]                      entry_rights_i,
  input  logic [acl_pkg::IdWidth-1:0]      cred_id_i,
  input  logic [15:0]                      requested_access_i,
  input  logic                             last_cred_i,
  // Result items.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [acl_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } st_e;

  st_e                           state_q, state_d;
  logic [acl_pkg::IdxWidth-1:0]  k_q, k_d;
  logic                          priv_q, priv_d;
  acl_pkg::id_t                  cred_q, cred_d;
  acl_pkg::rights_t              want_q, want_d;
  logic                          is_cred_q, is_cred_d;
  logic                          res_pend_q, res_pend_d;
  acl_pkg::status_e              res_status_q, res_status_d;
  acl_pkg::rights_t              gathered_q, gathered_d;
  logic                          decided_q, decided_d;
  logic                          verdict_q, verdict_d;
  logic [acl_pkg::CntWidth-1:0]  count_q, count_d;
  logic [acl_pkg::GenWidth-1:0]  gen_q, gen_d;
  acl_pkg::id_t                  priv_id_q, priv_id_d;
  acl_pkg::id_t                  wild_id_q, wild_id_d;
  logic                          out_valid_q, out_valid_d;
  acl_pkg::status_e              status_q, status_d;

  logic                          accept;
  logic                          out_free;
  logic [acl_pkg::GenWidth-1:0]  gen_inc;
  logic [acl_pkg::CntWidth-1:0]  len_clamped;
  logic [acl_pkg::CntWidth-1:0]  k_next;
  logic                          k_last;
  logic                          tbl_wr_en;
  acl_pkg::id_t                  rd_id;
  acl_pkg::rights_t              rd_rights;
  acl_pkg::match_req_t           mreq;
  acl_pkg::match_rsp_t           mrsp;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  assign gen_inc     = gen_q + acl_pkg::GenWidth'(1);
  assign len_clamped = (32'(list_length_i) > acl_pkg::AclDepth)
                       ? acl_pkg::CntWidth'(acl_pkg::AclDepth)
                       : acl_pkg::CntWidth'(list_length_i);
  assign k_next      = acl_pkg::CntWidth'(k_q) + acl_pkg::CntWidth'(1);
  assign k_last      = (k_next >= count_q);

  // Entry writes go straight into the slot store; slots past the depth are dropped.
  assign tbl_wr_en = accept && (op_i == acl_pkg::OP_ENTRY)
                     && (32'(entry_index_i) < acl_pkg::AclDepth);

  acl_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (tbl_wr_en),
    .wr_idx_i    (acl_pkg::IdxWidth'(entry_index_i)),
    .wr_id_i     (entry_id_i),
    .wr_rights_i (acl_pkg::rights_t'(entry_rights_i)),
    .rd_idx_i    (k_q),
    .rd_id_o     (rd_id),
    .rd_rights_o (rd_rights)
  );

  // Operands for the slot under the walk pointer.
  always_comb begin
    mreq.priv_mode   = priv_q;
    mreq.cred_id     = cred_q;
    mreq.wildcard_id = wild_id_q;
    mreq.want        = want_q;
    mreq.gathered    = gathered_q;
    mreq.slot_id     = rd_id;
    mreq.slot_rights = rd_rights;
  end

  acl_match_unit u_match (
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // Sequencer: take an item, walk the slots if needed, then hand on the result.
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    priv_d       = priv_q;
    cred_d       = cred_q;
    want_d       = want_q;
    is_cred_d    = is_cred_q;
    res_pend_d   = res_pend_q;
    res_status_d = res_status_q;
    gathered_d   = gathered_q;
    decided_d    = decided_q;
    verdict_d    = verdict_q;
    count_d      = count_q;
    gen_d        = gen_q;
    priv_id_d    = priv_id_q;
    wild_id_d    = wild_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;

    // Configuration registers.
    if (cfg_valid_i) begin
      case (acl_pkg::cfg_reg_e'(cfg_index_i))
        acl_pkg::CFG_PRIVILEGED_ID: priv_id_d = cfg_data_i;
        acl_pkg::CFG_WILDCARD_ID:   wild_id_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d = '0;
          case (acl_pkg::op_e'(op_i))
            acl_pkg::OP_HEADER: begin
              is_cred_d  = 1'b0;
              res_pend_d = 1'b1;
              state_d    = ST_DONE;
              if ((generation_i != '0) && (generation_i != gen_inc)) begin
                res_status_d = acl_pkg::STATUS_REJECTED;
              end else begin
                res_status_d = acl_pkg::STATUS_OK;
                gen_d        = generation_i;
                count_d      = len_clamped;
              end
            end
            acl_pkg::OP_CRED: begin
              is_cred_d  = 1'b1;
              res_pend_d = last_cred_i;
              cred_d     = cred_id_i;
              want_d     = acl_pkg::rights_t'(requested_access_i);
              priv_d     = 1'b0;
              state_d    = ST_DONE;
              if (!decided_q) begin
                if (cred_id_i == priv_id_q) begin
                  decided_d = 1'b1;
                  if ((acl_pkg::rights_t'(requested_access_i)
                       & acl_pkg::rights_t'(acl_pkg::ExecuteMask)) == '0) begin
                    verdict_d = 1'b1;
                  end else begin
                    verdict_d = 1'b0;
                    priv_d    = 1'b1;
                    if (count_q != '0) begin
                      state_d = ST_WALK;
                    end
                  end
                end else if (count_q != '0) begin
                  state_d = ST_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        gathered_d = mrsp.gathered;
        if (mrsp.hit) begin
          decided_d = 1'b1;
          verdict_d = 1'b1;
          state_d   = ST_DONE;
        end else if (k_last) begin
          state_d = ST_DONE;
        end else begin
          k_d = acl_pkg::IdxWidth'(k_next);
        end
      end

      ST_DONE: begin
        if (!res_pend_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (is_cred_q) begin
            status_d   = verdict_q ? acl_pkg::STATUS_OK : acl_pkg::STATUS_DENIED;
            gathered_d = '0;
            decided_d  = 1'b0;
            verdict_d  = 1'b0;
          end else begin
            status_d = res_status_q;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, list header, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      priv_q       <= 1'b0;
      cred_q       <= '0;
      want_q       <= '0;
      is_cred_q    <= 1'b0;
      res_pend_q   <= 1'b0;
      res_status_q <= acl_pkg::STATUS_OK;
      gathered_q   <= '0;
      decided_q    <= 1'b0;
      verdict_q    <= 1'b0;
      count_q      <= acl_pkg::CntWidth'(1);
      gen_q        <= acl_pkg::GenWidth'(1);
      priv_id_q    <= acl_pkg::IdWidth'(1);
      wild_id_q    <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= acl_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      priv_q       <= priv_d;
      cred_q       <= cred_d;
      want_q       <= want_d;
      is_cred_q    <= is_cred_d;
      res_pend_q   <= res_pend_d;
      res_status_q <= res_status_d;
      gathered_q   <= gathered_d;
      decided_q    <= decided_d;
      verdict_q    <= verdict_d;
      count_q      <= count_d;
      gen_q        <= gen_d;
      priv_id_q    <= priv_id_d;
      wild_id_q    <= wild_id_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
    end
  end

`include "acl_access_checker_macros.svh"

  // The walk pointer stays inside the slots in use.
  `ACL_ASSERT_IMP(a_walk_in_range, state_q == ST_WALK, acl_pkg::CntWidth'(k_q) < count_q)
  // The stored list length never exceeds the depth.
  `ACL_ASSERT_IMP(a_count_bounded, 1'b1, 32'(count_q) <= acl_pkg::AclDepth)
  // A request's state is cleared once its verdict has been handed on.
  `ACL_ASSERT_NXT(a_request_cleared,
                  state_q == ST_DONE && res_pend_q && is_cred_q && out_free,
                  !decided_q && !verdict_q && gathered_q == '0)
  // An execute check for the privileged id leaves the gathered rights alone.
  `ACL_ASSERT_NXT(a_priv_walk_keeps_rights, state_q == ST_WALK && priv_q, $stable(gathered_q))

endmodule

### tb/tb.sv
// Self-checking testbench for the access control list checker.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 375;
  localparam int unsigned IdleChance   = 31;
  localparam int unsigned PoolSize     = 6;
  localparam logic [1:0]  OpUnused     = 2'd3;

  // One input item with the status to expect, where the table gives it.
  typedef struct packed {
    logic [1:0]                     op;
    acl_pkg::id_t                   generation;
    logic [acl_pkg::InLenWidth-1:0] list_length;
    logic [acl_pkg::InIdxWidth-1:0] entry_index;
    acl_pkg::id_t                   entry_id;
    acl_pkg::rights_t               entry_rights;
    acl_pkg::id_t                   cred_id;
    acl_pkg::rights_t               want;
    logic                           is_last;
    logic                           has_status;
    acl_pkg::status_e               status;
  } stim_t;

  logic              clk = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall_o;
  stim_t             offer;
  logic              out_valid_o;
  logic              out_stall;
  logic [1:0]        status_o;
  logic              cfg_valid;
  logic              cfg_ready_o;
  acl_pkg::cfg_reg_e cfg_index;
  acl_pkg::id_t      cfg_data;

  // Mirror of the list, the header state, the request and the registers.
  acl_pkg::id_t     slot_id [acl_pkg::AclDepth];
  acl_pkg::rights_t slot_rights [acl_pkg::AclDepth];
  int               slots_used;
  acl_pkg::id_t     cur_gen;
  acl_pkg::rights_t rights_seen;
  bit               req_done;
  bit               req_granted;
  acl_pkg::id_t     priv_reg;
  acl_pkg::id_t     wild_reg;

  acl_pkg::status_e pending_status[$];
  stim_t            directed_rows[$];
  acl_pkg::id_t     id_pool [PoolSize];
  int               errors;
  int               cycles;
  bit               quiet;
  bit               hold_request;
  int               hold_left;

  acl_access_checker dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .op_i               (offer.op),
    .generation_i       (offer.generation),
    .list_length_i      (offer.list_length),
    .entry_index_i      (offer.entry_index),
    .entry_id_i         (offer.entry_id),
    .entry_rights_i     (offer.entry_rights),
    .cred_id_i          (offer.cred_id),
    .requested_access_i (offer.want),
    .last_cred_i        (offer.is_last),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .status_o           (status_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("%0t: run exceeded %0d cycles", $time, LimitCycles);
      $display("acl_access_checker regression: fail");
      $finish;
    end
  end

  // One credential against the list; the privileged id decides at once.
  function automatic void walk_credential(acl_pkg::id_t id, acl_pkg::rights_t want);
    if (id == priv_reg) begin
      req_done = 1'b1;
      if ((want & acl_pkg::rights_t'(acl_pkg::ExecuteMask)) == '0) begin
        req_granted = 1'b1;
        return;
      end
      req_granted = 1'b0;
      for (int k = 0; k < slots_used; k++) begin
        if ((slot_rights[k] & acl_pkg::rights_t'(acl_pkg::ExecuteMask)) != '0) begin
          req_granted = 1'b1;
          break;
        end
      end
      return;
    end
    for (int k = 0; k < slots_used; k++) begin
      if (slot_id[k] == id || slot_id[k] == wild_reg) begin
        rights_seen = rights_seen | slot_rights[k];
        if ((rights_seen & want) == want) begin
          req_done    = 1'b1;
          req_granted = 1'b1;
          return;
        end
      end
    end
  endfunction

  // Applies one accepted item to the mirror; returns 1 when it gives a status.
  function automatic bit acl_outcome(stim_t it, output acl_pkg::status_e st);
    st = acl_pkg::STATUS_OK;
    case (it.op)
      acl_pkg::OP_HEADER: begin
        if (it.generation != '0 && it.generation != cur_gen + 32'd1) begin
          st = acl_pkg::STATUS_REJECTED;
          return 1'b1;
        end
        cur_gen    = it.generation;
        slots_used = (it.list_length > acl_pkg::AclDepth) ? int'(acl_pkg::AclDepth)
                                                          : int'(it.list_length);
        return 1'b1;
      end
      acl_pkg::OP_ENTRY: begin
        slot_id[it.entry_index]     = it.entry_id;
        slot_rights[it.entry_index] = it.entry_rights;
        return 1'b0;
      end
      acl_pkg::OP_CRED: begin
        if (!req_done) walk_credential(it.cred_id, it.want);
        if (!it.is_last) return 1'b0;
        st          = req_granted ? acl_pkg::STATUS_OK : acl_pkg::STATUS_DENIED;
        rights_seen = '0;
        req_done    = 1'b0;
        req_granted = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Port watcher: register writes, accepted items and results, in that order.
  always @(posedge clk) begin : watch_ports
    bit               gives;
    acl_pkg::status_e st;
    acl_pkg::status_e want_st;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          acl_pkg::CFG_PRIVILEGED_ID: priv_reg = cfg_data;
          acl_pkg::CFG_WILDCARD_ID:   wild_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall_o) begin
        gives = acl_outcome(offer, st);
        if (gives) pending_status.push_back(offer.has_status ? offer.status : st);
      end
      if (out_valid_o && !out_stall) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d", $time, status_o);
          errors++;
        end else begin
          want_st = pending_status.pop_front();
          if (status_o !== want_st) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want_st, status_o);
            errors++;
          end
        end
      end
    end
  end

  // Result side stalls at random, never in a quiet stretch, and holds off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IdleChance);
    end
  end

  // Item builders; fields an op does not use carry random bits.
  function automatic stim_t blank(logic [1:0] op);
    stim_t r;
    r.op           = op;
    r.generation   = $urandom;
    r.list_length  = acl_pkg::InLenWidth'($urandom);
    r.entry_index  = acl_pkg::InIdxWidth'($urandom);
    r.entry_id     = $urandom;
    r.entry_rights = acl_pkg::rights_t'($urandom);
    r.cred_id      = $urandom;
    r.want         = acl_pkg::rights_t'($urandom);
    r.is_last      = 1'($urandom);
    r.has_status   = 1'b0;
    r.status       = acl_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic stim_t header(acl_pkg::id_t gen, logic [acl_pkg::InLenWidth-1:0] len);
    stim_t r;
    r             = blank(acl_pkg::OP_HEADER);
    r.generation  = gen;
    r.list_length = len;
    return r;
  endfunction

  function automatic stim_t entry(logic [acl_pkg::InIdxWidth-1:0] idx, acl_pkg::id_t id,
                                  acl_pkg::rights_t rights);
    stim_t r;
    r              = blank(acl_pkg::OP_ENTRY);
    r.entry_index  = idx;
    r.entry_id     = id;
    r.entry_rights = rights;
    return r;
  endfunction

  function automatic stim_t cred(acl_pkg::id_t id, acl_pkg::rights_t want, logic is_last);
    stim_t r;
    r         = blank(acl_pkg::OP_CRED);
    r.cred_id = id;
    r.want    = want;
    r.is_last = is_last;
    return r;
  endfunction

  function automatic stim_t with_status(stim_t r, acl_pkg::status_e s);
    r.has_status = 1'b1;
    r.status     = s;
    return r;
  endfunction

  // Random field values, biased towards ids and rights that hit the list.
  function automatic acl_pkg::id_t pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return priv_reg;
    if (r < 35) return wild_reg;
    if (r < 80) return id_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  function automatic acl_pkg::rights_t pick_rights();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return acl_pkg::rights_t'(1) << $urandom_range(0, acl_pkg::RightsWidth - 1);
    if (r < 70) return acl_pkg::rights_t'($urandom & $urandom);
    return acl_pkg::rights_t'($urandom);
  endfunction

  function automatic acl_pkg::rights_t pick_want();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return acl_pkg::rights_t'(1) << $urandom_range(0, 3);
    if (r < 60) return (acl_pkg::rights_t'(1) << $urandom_range(0, 15))
                       | (acl_pkg::rights_t'(1) << $urandom_range(0, 3));
    if (r < 75) return acl_pkg::rights_t'(acl_pkg::ExecuteMask)
                       | acl_pkg::rights_t'($urandom_range(0, 3));
    if (r < 85) return '0;
    if (r < 95) return '1;
    return acl_pkg::rights_t'($urandom);
  endfunction

  function automatic stim_t pick_header();
    int                             r;
    acl_pkg::id_t                   gen;
    logic [acl_pkg::InLenWidth-1:0] len;
    r   = $urandom_range(0, 99);
    gen = (r < 15) ? acl_pkg::id_t'(0) : (r < 85) ? cur_gen + 32'd1 : acl_pkg::id_t'($urandom);
    len = ($urandom_range(0, 19) == 0) ? acl_pkg::InLenWidth'($urandom_range(17, 31))
                                       : acl_pkg::InLenWidth'($urandom_range(0, acl_pkg::AclDepth));
    return header(gen, len);
  endfunction

  function automatic stim_t pick_entry();
    acl_pkg::id_t id;
    id = ($urandom_range(0, 99) < 60) ? id_pool[$urandom_range(0, PoolSize - 1)] : $urandom;
    return entry(acl_pkg::InIdxWidth'($urandom_range(0, acl_pkg::AclDepth - 1)), id,
                 pick_rights());
  endfunction

  // Offers one item, idling at random beforehand, and waits until it is taken.
  task automatic send_item(stim_t it);
    while (!quiet && $urandom_range(0, 99) < IdleChance) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    offer    <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  // Writes one register; called only while the block is idle.
  task automatic write_register(acl_pkg::cfg_reg_e idx, acl_pkg::id_t value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for every outstanding status, then lets trailing work finish.
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_status.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Mostly whole requests, with list updates, broken requests and unused ops mixed in.
  task automatic random_items(int unsigned count);
    int               sent;
    int               r;
    int               n_creds;
    acl_pkg::rights_t want;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        n_creds = $urandom_range(1, 4);
        want    = pick_want();
        for (int k = 0; k < n_creds; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item($urandom_range(0, 1) ? pick_entry() : pick_header());
            sent++;
          end
          send_item(cred(pick_id(), want, k == n_creds - 1));
          sent++;
        end
      end else if (r < 77) begin
        send_item(pick_entry());
        sent++;
      end else if (r < 90) begin
        send_item(pick_header());
        sent++;
      end else if (r < 97) begin
        send_item(cred(pick_id(), pick_want(), 1'b0));
        sent++;
      end else begin
        send_item(blank(OpUnused));
      end
    end
  endtask

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    acl_pkg::id_t shared_id;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    offer        = blank(acl_pkg::OP_CRED);
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = acl_pkg::CFG_PRIVILEGED_ID;
    cfg_data     = '0;
    errors       = 0;
    cycles       = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    hold_left    = 0;
    priv_reg     = 32'd1;
    wild_reg     = '0;
    for (int k = 0; k < acl_pkg::AclDepth; k++) begin
      slot_id[k]     = '0;
      slot_rights[k] = '0;
    end
    slot_id[0]     = wild_reg;
    slot_rights[0] = acl_pkg::rights_t'(acl_pkg::ReferenceMask);
    slots_used     = 1;
    cur_gen        = 32'd1;
    rights_seen    = '0;
    req_done       = 1'b0;
    req_granted    = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed table under the reset settings.
    directed_rows.push_back(with_status(cred(32'd5, 16'h0001, 1'b1), acl_pkg::STATUS_OK));
    directed_rows.push_back(with_status(cred(32'd1, 16'h0002, 1'b1), acl_pkg::STATUS_OK));
    directed_rows.push_back(with_status(cred(32'd1, 16'h0004, 1'b1), acl_pkg::STATUS_DENIED));
    directed_rows.push_back(with_status(cred(32'd7, 16'h0002, 1'b1), acl_pkg::STATUS_DENIED));
    directed_rows.push_back(with_status(header(32'd5, 5'd3), acl_pkg::STATUS_REJECTED));
    directed_rows.push_back(with_status(header(32'd2, 5'd16), acl_pkg::STATUS_OK));
    directed_rows.push_back(entry(4'd15, 32'hFFFF_FFFF, 16'hFFFF));
    directed_rows.push_back(entry(4'd1, 32'h1234_5678, 16'h0006));
    directed_rows.push_back(cred(32'h1234_5678, 16'h0007, 1'b0));
    directed_rows.push_back(cred(32'hDEAD_BEEF, 16'h0007, 1'b1));
    directed_rows.push_back(cred(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    directed_rows.push_back(cred(32'd1, 16'h0004, 1'b1));
    directed_rows.push_back(with_status(header(32'd0, 5'd31), acl_pkg::STATUS_OK));
    directed_rows.push_back(with_status(header(32'hFFFF_FFFF, 5'd0), acl_pkg::STATUS_REJECTED));
    directed_rows.push_back(with_status(header(32'd1, 5'd0), acl_pkg::STATUS_OK));
    directed_rows.push_back(cred(32'd5, 16'h0000, 1'b1));
    directed_rows.push_back(with_status(cred(32'd1, 16'h0004, 1'b1), acl_pkg::STATUS_DENIED));
    directed_rows.push_back(blank(OpUnused));
    directed_rows.push_back(cred(32'h1234_5678, 16'h0002, 1'b0));
    directed_rows.push_back(with_status(header(32'd2, 5'd2), acl_pkg::STATUS_OK));
    directed_rows.push_back(entry(4'd2, 32'd0, 16'h0000));
    directed_rows.push_back(cred(32'h1234_5678, 16'h0002, 1'b1));
    directed_rows.push_back(entry(4'd0, 32'hABCD_0123, 16'h8000));
    directed_rows.push_back(cred(32'hABCD_0123, 16'h8000, 1'b1));
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    settle();

    // Random phases: two extreme settings, the second one quiet, a hold-off, equal ids.
    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: begin
          write_register(acl_pkg::CFG_PRIVILEGED_ID, '0);
          write_register(acl_pkg::CFG_WILDCARD_ID, '1);
        end
        2: begin
          write_register(acl_pkg::CFG_PRIVILEGED_ID, '1);
          write_register(acl_pkg::CFG_WILDCARD_ID, '0);
          quiet = 1'b1;
        end
        3: begin
          write_register(acl_pkg::CFG_PRIVILEGED_ID, $urandom);
          write_register(acl_pkg::CFG_WILDCARD_ID, $urandom);
          hold_request = 1'b1;
        end
        default: begin
          shared_id = $urandom;
          write_register(acl_pkg::CFG_PRIVILEGED_ID, shared_id);
          write_register(acl_pkg::CFG_WILDCARD_ID, shared_id);
        end
      endcase
      id_pool[0] = priv_reg;
      id_pool[1] = wild_reg;
      id_pool[2] = '0;
      id_pool[3] = '1;
      id_pool[4] = $urandom;
      id_pool[5] = $urandom;
      random_items(PhaseItems);
      settle();
      quiet = 1'b0;
    end

    if (pending_status.size() != 0) begin
      $display("%0t: %0d results never arrived, next expected %0d", $time,
               pending_status.size(), pending_status[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("acl_access_checker regression: pass");
    end else begin
      $display("acl_access_checker regression: fail");
    end
    $finish;
  end

endmodule
